[src/bb3_pkg.sv]
// Shared constants and types for the bijective base-3 converter.
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int VALUE_W        = 32;
    localparam int DIGIT_W        = 2;
    localparam int BIT_CNT_W      = $clog2(VALUE_W);
    localparam int MAX_DIGITS_DEF = 20;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

endpackage

[src/bb3_div3.sv]
// Bit-serial step unit: decrements the value, then divides it by three.
`timescale 1ns / 1ps

module bb3_div3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [bb3_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_start,
    output bb3_pkg::t_div_stat            o_stat
);
    import bb3_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DEC  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

    logic [VALUE_W-1:0]   r_val,   n_val;
    logic [1:0]           r_phase, n_phase;
    logic [BIT_CNT_W-1:0] r_bit,   n_bit;
    logic                 r_borrow, n_borrow;
    logic                 r_nz,    n_nz;
    logic [1:0]           r_rem,   n_rem;
    logic                 r_done,  n_done;
    logic                 r_zero,  n_zero;
    logic [DIGIT_W-1:0]   r_digit, n_digit;
    logic [2:0]           w_trial;
    logic                 w_qbit;

    always_comb begin
        n_val    = r_val;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_borrow = r_borrow;
        n_nz     = r_nz;
        n_rem    = r_rem;
        n_done   = 1'b0;
        n_zero   = r_zero;
        n_digit  = r_digit;
        w_trial  = {r_rem, r_val[VALUE_W-1]};
        w_qbit   = (w_trial >= 3'd3);
        case (r_phase)
            P_IDLE: begin
                if (i_load) begin
                    n_val = i_value;
                end
                if (i_start) begin
                    n_phase  = P_DEC;
                    n_bit    = '0;
                    n_borrow = 1'b1;
                    n_nz     = 1'b0;
                end
            end
            P_DEC: begin
                n_val    = {r_val[0] ^ r_borrow, r_val[VALUE_W-1:1]};
                n_borrow = r_borrow & ~r_val[0];
                n_nz     = r_nz | r_val[0];
                n_bit    = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_bit = '0;
                    n_rem = 2'd0;
                    if (!n_nz) begin
                        n_phase = P_IDLE;
                        n_done  = 1'b1;
                        n_zero  = 1'b1;
                    end else begin
                        n_phase = P_DIV;
                    end
                end
            end
            P_DIV: begin
                n_val = {r_val[VALUE_W-2:0], w_qbit};
                n_rem = w_qbit ? 2'(w_trial - 3'd3) : w_trial[1:0];
                n_bit = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                    n_zero  = 1'b0;
                    n_digit = n_rem + 2'd1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_val    <= n_val;
        r_bit    <= n_bit;
        r_borrow <= n_borrow;
        r_nz     <= n_nz;
        r_rem    <= n_rem;
        r_zero   <= n_zero;
        r_digit  <= n_digit;
    end

    assign o_stat.done  = r_done;
    assign o_stat.zero  = r_zero;
    assign o_stat.digit = r_digit;

endmodule

[src/bb3_stack.sv]
// Digit stack built as a shift register, read at its top entry only.
`timescale 1ns / 1ps

module bb3_stack #(
    parameter int DEPTH = bb3_pkg::MAX_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [bb3_pkg::DIGIT_W-1:0]    i_digit,
    input  logic                           i_pop,
    output logic [bb3_pkg::DIGIT_W-1:0]    o_top,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    import bb3_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DIGIT_W-1:0] r_stk [DEPTH];
    logic [CNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < DEPTH; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_top   = r_stk[0];
    assign o_count = r_cnt;

endmodule

[src/bijective_base3_converter.sv]
// Top level of the bijective base-3 converter: sequencing and result register.
//
//   Channel   Direction  Transfer when         Payload
//   command   in         start && !busy        i_value
//   result    out        o_valid (one cycle)   o_digit, o_last
//
// Each digit takes a decrement pass and a divide-by-three pass in the bit-serial
// step unit, then a handoff of the digit to the stack. The run ends with one
// more decrement pass that finds the value zero, unless MAX_DIGITS digits are
// found first. Digits then leave the stack at one per cycle, most significant
// first. A zero input gives no digits and busy falls with no result shown.
// Reset clears the sequencer, the stack count and the result strobe.
// Results cannot be stalled; busy falls in the cycle that shows the last digit.
`timescale 1ns / 1ps

module bijective_base3_converter #(
    parameter int MAX_DIGITS = bb3_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bb3_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_valid,
    output logic [bb3_pkg::DIGIT_W-1:0]   o_digit,
    output logic                          o_last
);
    import bb3_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic               r_valid, n_valid;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_last,  n_last;
    logic               w_load, w_start, w_push, w_pop;
    t_div_stat          w_stat;
    logic [DIGIT_W-1:0] w_top;
    logic [CNT_W-1:0]   w_count;

    bb3_div3 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_value (i_value),
        .i_start (w_start),
        .o_stat  (w_stat)
    );

    bb3_stack #(
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_digit (w_stat.digit),
        .i_pop   (w_pop),
        .o_top   (w_top),
        .o_count (w_count)
    );

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_digit = r_digit;
        n_last  = 1'b0;
        w_load  = 1'b0;
        w_start = 1'b0;
        w_push  = 1'b0;
        w_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_load  = 1'b1;
                    w_start = 1'b1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_stat.done) begin
                    if (w_stat.zero) begin
                        n_state = (w_count == '0) ? S_IDLE : S_EMIT;
                    end else begin
                        w_push = 1'b1;
                        if (w_count == CNT_W'(MAX_DIGITS - 1)) begin
                            n_state = S_EMIT;
                        end else begin
                            w_start = 1'b1;
                        end
                    end
                end
            end
            S_EMIT: begin
                w_pop   = 1'b1;
                n_valid = 1'b1;
                n_digit = w_top;
                n_last  = (w_count == CNT_W'(1));
                if (n_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_digit <= n_digit;
        r_last  <= n_last;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_digit = r_digit;
    assign o_last  = r_valid & r_last;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_EMIT))
        else $error("Result shown outside the emit phase.");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid)
        else $error("Result follows the last digit of a run.");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Command transfer did not raise busy.");

    a_digit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit != 2'd0))
        else $error("Zero digit emitted.");

endmodule
